### hw/rtl/assert_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression that must never be true outside of reset
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

### hw/rtl/tts_pkg.sv
// types and constants of the time triggered task scheduler
package tts_pkg;

	localparam int SLOT_W      = 3;
	localparam int DATA_W      = 32;
	localparam int OP_W        = 3;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 40;

	localparam logic [DATA_W-1:0] ELAPSED_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_DISPATCH = 3'd1,
		OP_ADD      = 3'd2,
		OP_DELETE   = 3'd3,
		OP_MODIFY   = 3'd4,
		OP_INIT     = 3'd5
	} op_t;

	// one slot entry of the period / elapsed memory
	typedef struct packed {
		logic [DATA_W-1:0] period;
		logic [DATA_W-1:0] elapsed;
	} slot_word_t;

	// verdict of the shared compare / increment unit
	typedef struct packed {
		logic              due;
		logic [DATA_W-1:0] next_elapsed;
	} alu_res_t;

	typedef struct packed {
		logic              last;
		logic              overrun_error;
		logic              status;
		logic [DATA_W-1:0] old_period;
		logic              due_valid;
		logic [SLOT_W-1:0] due_slot;
	} result_t;

endpackage

### hw/rtl/tts_mem.sv
// slot memory: one write port, one registered read port
module tts_mem #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/tts_alu.sv
// shared compare and saturating increment unit for one slot
module tts_alu import tts_pkg::*; (
	input  slot_word_t word,
	output alu_res_t   verdict
);

	always_comb begin
		verdict.due = (word.elapsed >= word.period);
		if (verdict.due) begin
			// count restarts at zero and then takes this tick
			verdict.next_elapsed = DATA_W'(1);
		end else if (word.elapsed == ELAPSED_MAX) begin
			verdict.next_elapsed = word.elapsed;
		end else begin
			verdict.next_elapsed = word.elapsed + DATA_W'(1);
		end
	end

endmodule

### hw/rtl/time_triggered_task_scheduler_top.sv
// time triggered task scheduler: sequencer over the slot memory and compare unit
// one transaction at a time; tick, delete, init, unused ops: result out the next cycle
// add: one active bit examined per cycle after the accept, up to the first free slot
// modify of a valid slot: waits on the registered read of the slot memory
// dispatch: SCAN each slot, EVAL each active one, then DONE, plus output stalls
// arst_n clears all control state, active and period-valid bits; no clearing pass
`include "assert_macros.svh"

module time_triggered_task_scheduler_top import tts_pkg::*; #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [2:0] slot, [34:3] period_ticks, [66:35] start_delay, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [2:0] op
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] due_slot, [3] due_valid, [35:4] old_period, [36] status,
	// [37] overrun_error, rest zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_MOD,
		ST_SCAN,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [IW-1:0]         idx_q;
	logic [DATA_W-1:0]     per_q;
	logic [DATA_W-1:0]     dly_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  hold_valid_q;
	logic [IW-1:0]         hold_slot_q;
	logic [NUM_SLOTS-1:0]  active_q;
	logic [NUM_SLOTS-1:0]  pvalid_q;
	logic                  pending_q;
	logic                  overrun_q;
	result_t               out_q;
	logic                  m_tvalid_q;

	op_t                   in_op;
	logic [SLOT_W-1:0]     in_slot;
	logic [DATA_W-1:0]     in_per;
	logic [DATA_W-1:0]     in_dly;
	logic [IW-1:0]         in_idx;
	logic                  slot_ok;
	logic                  out_free;
	logic                  accept;
	logic                  last_slot;
	logic                  report_ok;
	logic                  eval_go;
	logic                  out_load;

	logic                  mem_we;
	logic [IW-1:0]         mem_raddr;
	slot_word_t            mem_wdata;
	slot_word_t            mem_rdata;
	alu_res_t              alu_out;

	function automatic result_t mk_res(logic [SLOT_W-1:0] dslot, logic dvalid,
		logic [DATA_W-1:0] oldp, logic stat, logic ovr, logic lst);
		result_t r;
		r.due_slot      = dslot;
		r.due_valid     = dvalid;
		r.old_period    = oldp;
		r.status        = stat;
		r.overrun_error = ovr;
		r.last          = lst;
		return r;
	endfunction

	assign in_op   = op_t'(s_tuser);
	assign in_slot = s_tdata[2:0];
	assign in_per  = s_tdata[34:3];
	assign in_dly  = s_tdata[66:35];
	assign in_idx  = IW'(in_slot);
	assign slot_ok = (int'(in_slot) < NUM_SLOTS);

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign last_slot = (idx_q == IW'(NUM_SLOTS - 1));
	assign report_ok = (cnt_q < CNT_W'(MAX_RESULTS));
	// a new due slot pushes the held one out, which needs a free output register
	assign eval_go   = !(alu_out.due && report_ok && hold_valid_q && !out_free);

	tts_mem #(
		.DEPTH(NUM_SLOTS),
		.WIDTH($bits(slot_word_t))
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(idx_q),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	tts_alu u_alu (
		.word   (mem_rdata),
		.verdict(alu_out)
	);

	always_comb begin
		mem_raddr = (state_q == ST_IDLE) ? in_idx : idx_q;
		mem_we    = 1'b0;
		mem_wdata = mem_rdata;
		case (state_q)
			ST_ADD: begin
				mem_we            = !active_q[idx_q];
				mem_wdata.period  = per_q;
				mem_wdata.elapsed = dly_q;
			end
			ST_MOD: begin
				mem_we           = 1'b1;
				mem_wdata.period = per_q;
			end
			ST_EVAL: begin
				mem_we            = eval_go;
				mem_wdata.elapsed = alu_out.next_elapsed;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// a result transaction is loaded into the output register this cycle
	always_comb begin
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				out_load = accept && (in_op != OP_DISPATCH) && (in_op != OP_ADD) &&
					!((in_op == OP_MODIFY) && slot_ok);
			end
			ST_ADD: begin
				out_load = !active_q[idx_q] || last_slot;
			end
			ST_MOD: begin
				out_load = 1'b1;
			end
			ST_EVAL: begin
				out_load = eval_go && alu_out.due && report_ok && hold_valid_q;
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			per_q        <= '0;
			dly_q        <= '0;
			cnt_q        <= '0;
			hold_valid_q <= 1'b0;
			hold_slot_q  <= '0;
			active_q     <= '0;
			pvalid_q     <= '0;
			pending_q    <= 1'b0;
			overrun_q    <= 1'b0;
			out_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= ((in_op == OP_DISPATCH) || (in_op == OP_ADD)) ? '0 : in_idx;
						per_q <= in_per;
						dly_q <= in_dly;
						case (in_op)
							OP_TICK: begin
								if (pending_q) begin
									overrun_q <= 1'b1;
								end else begin
									pending_q <= 1'b1;
								end
								out_q      <= mk_res('0, 1'b0, '0, 1'b0,
									overrun_q | pending_q, 1'b1);
							end
							OP_DISPATCH: begin
								cnt_q        <= '0;
								hold_valid_q <= 1'b0;
								state_q      <= ST_SCAN;
							end
							OP_ADD: begin
								state_q <= ST_ADD;
							end
							OP_DELETE: begin
								if (slot_ok) begin
									active_q[in_idx] <= 1'b0;
									pvalid_q[in_idx] <= 1'b0;
								end
								out_q      <= mk_res('0, 1'b0, '0, 1'b0, overrun_q, 1'b1);
							end
							OP_MODIFY: begin
								if (slot_ok) begin
									state_q <= ST_MOD;
								end else begin
									out_q      <= mk_res('0, 1'b0, '0, 1'b0, overrun_q, 1'b1);
								end
							end
							OP_INIT: begin
								active_q   <= '0;
								pvalid_q   <= '0;
								pending_q  <= 1'b0;
								overrun_q  <= 1'b0;
								out_q      <= mk_res('0, 1'b0, '0, 1'b0, 1'b0, 1'b1);
							end
							default: begin
								out_q      <= mk_res('0, 1'b0, '0, 1'b0, overrun_q, 1'b1);
							end
						endcase
					end
				end
				ST_ADD: begin
					if (!active_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
						pvalid_q[idx_q] <= 1'b1;
						out_q      <= mk_res(SLOT_W'(idx_q), 1'b1, '0, 1'b0, overrun_q, 1'b1);
						state_q    <= ST_IDLE;
					end else if (last_slot) begin
						// table full
						out_q      <= mk_res('0, 1'b0, '0, 1'b1, overrun_q, 1'b1);
						state_q    <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_MOD: begin
					pvalid_q[idx_q] <= 1'b1;
					out_q      <= mk_res('0, 1'b0,
						pvalid_q[idx_q] ? mem_rdata.period : '0, 1'b0, overrun_q, 1'b1);
					state_q    <= ST_IDLE;
				end
				ST_SCAN: begin
					if (active_q[idx_q]) begin
						state_q <= ST_EVAL;
					end else if (last_slot) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_EVAL: begin
					if (eval_go) begin
						if (alu_out.due && report_ok) begin
							cnt_q        <= cnt_q + CNT_W'(1);
							hold_valid_q <= 1'b1;
							hold_slot_q  <= idx_q;
							if (hold_valid_q) begin
								out_q      <= mk_res(SLOT_W'(hold_slot_q), 1'b1, '0, 1'b0,
									overrun_q, 1'b0);
							end
						end
						if (last_slot) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						// held transaction, or an empty one when nothing was due
						out_q        <= mk_res(hold_valid_q ? SLOT_W'(hold_slot_q) : '0,
							hold_valid_q, '0, 1'b0, overrun_q, 1'b1);
						pending_q    <= 1'b0;
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = OUT_DATA_W'({out_q.overrun_error, out_q.status, out_q.old_period,
		out_q.due_valid, out_q.due_slot});

	`ASSERT_NEVER(a_hold_empty_idle, (state_q == ST_IDLE) && hold_valid_q,
		"held dispatch transaction left over in idle")
	`ASSERT_NEVER(a_cnt_range, cnt_q > CNT_W'(MAX_RESULTS),
		"dispatch reported more transactions than allowed")
	`ASSERT_CLK(a_eval_active, (state_q == ST_EVAL) |-> active_q[idx_q],
		"evaluating an inactive slot")
	`ASSERT_CLK(a_done_clears_pending, ((state_q == ST_DONE) && out_free) |=> !pending_q,
		"tick still pending after dispatch")

endmodule

### tb/sv/tts_sched_checker.sv
// checker for the task scheduler: predicts the results of every accepted transaction and compares them
module tts_sched_checker import tts_pkg::*; #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// [2:0] slot, [34:3] period_ticks, [66:35] start_delay, rest zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [2:0] op
	input  logic [OP_W-1:0]       s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// [2:0] due_slot, [3] due_valid, [35:4] old_period, [36] status, [37] overrun_error
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tlast,
	output int                    fail_cnt,
	output int                    answers_waiting,
	output int                    answers_seen,
	output int                    slot_answers
);
	timeunit 1ns;
	timeprecision 1ps;

	logic              slot_on  [NUM_SLOTS];
	logic [DATA_W-1:0] slot_per [NUM_SLOTS];
	logic [DATA_W-1:0] slot_age [NUM_SLOTS];
	logic              tick_pend;
	logic              overrun;
	result_t           table_answers_q[$];

	initial begin
		fail_cnt        = 0;
		answers_waiting = 0;
		answers_seen    = 0;
		slot_answers    = 0;
	end

	task wipe_slots();
		int i;
		for (i = 0; i < NUM_SLOTS; i++) begin
			slot_on[i]  = 1'b0;
			slot_per[i] = '0;
			slot_age[i] = '0;
		end
		tick_pend = 1'b0;
		overrun   = 1'b0;
	endtask

	// overrun is sampled as it stands after the operation
	task push_answer(input logic [SLOT_W-1:0] slot, input logic valid,
			input logic [DATA_W-1:0] prev, input logic full, input logic fin);
		result_t r;
		r.due_slot      = slot;
		r.due_valid     = valid;
		r.old_period    = prev;
		r.status        = full;
		r.overrun_error = overrun;
		r.last          = fin;
		table_answers_q.push_back(r);
	endtask

	task run_table_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
			input logic [DATA_W-1:0] per, input logic [DATA_W-1:0] dly);
		int i;
		int k;
		int free_idx;
		int n_due;
		int due_list [NUM_SLOTS];
		logic [DATA_W-1:0] prev;
		case (op)
			OP_TICK: begin
				if (tick_pend)
					overrun = 1'b1;
				else
					tick_pend = 1'b1;
				push_answer('0, 1'b0, '0, 1'b0, 1'b1);
			end
			OP_DISPATCH: begin
				n_due = 0;
				for (i = 0; i < NUM_SLOTS; i++) begin
					if (slot_on[i]) begin
						if (slot_age[i] >= slot_per[i]) begin
							slot_age[i] = '0;
							if (n_due < MAX_RESULTS) begin
								due_list[n_due] = i;
								n_due++;
							end
						end
						if (slot_age[i] != ELAPSED_MAX)
							slot_age[i] = slot_age[i] + 1'b1;
					end
				end
				tick_pend = 1'b0;
				if (n_due == 0)
					push_answer('0, 1'b0, '0, 1'b0, 1'b1);
				for (k = 0; k < n_due; k++)
					push_answer(SLOT_W'(due_list[k]), 1'b1, '0, 1'b0, k == n_due - 1);
			end
			OP_ADD: begin
				free_idx = -1;
				for (i = 0; i < NUM_SLOTS; i++)
					if (!slot_on[i] && free_idx < 0)
						free_idx = i;
				if (free_idx < 0) begin
					push_answer('0, 1'b0, '0, 1'b1, 1'b1);
				end else begin
					slot_on[free_idx]  = 1'b1;
					slot_per[free_idx] = per;
					slot_age[free_idx] = dly;
					push_answer(SLOT_W'(free_idx), 1'b1, '0, 1'b0, 1'b1);
				end
			end
			OP_DELETE: begin
				// elapsed count survives a delete
				if (slot < NUM_SLOTS) begin
					slot_on[slot]  = 1'b0;
					slot_per[slot] = '0;
				end
				push_answer('0, 1'b0, '0, 1'b0, 1'b1);
			end
			OP_MODIFY: begin
				prev = '0;
				if (slot < NUM_SLOTS) begin
					prev           = slot_per[slot];
					slot_per[slot] = per;
				end
				push_answer('0, 1'b0, prev, 1'b0, 1'b1);
			end
			OP_INIT: begin
				wipe_slots();
				push_answer('0, 1'b0, '0, 1'b0, 1'b1);
			end
			default: begin
				push_answer('0, 1'b0, '0, 1'b0, 1'b1);
			end
		endcase
	endtask

	task compare_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	task check_answer();
		result_t want;
		if (table_answers_q.size() == 0) begin
			$error("result transaction with nothing expected: tdata 0x%0h tlast %0b",
				m_tdata, m_tlast);
			fail_cnt++;
		end else begin
			want = table_answers_q.pop_front();
			answers_seen++;
			if (want.due_valid)
				slot_answers++;
			compare_field("due_slot", DATA_W'(want.due_slot), DATA_W'(m_tdata[SLOT_W-1:0]));
			compare_field("due_valid", DATA_W'(want.due_valid), DATA_W'(m_tdata[SLOT_W]));
			compare_field("old_period", want.old_period, m_tdata[SLOT_W+1 +: DATA_W]);
			compare_field("status", DATA_W'(want.status), DATA_W'(m_tdata[SLOT_W+DATA_W+1]));
			compare_field("overrun_error", DATA_W'(want.overrun_error),
				DATA_W'(m_tdata[SLOT_W+DATA_W+2]));
			compare_field("tdata padding", '0, DATA_W'(m_tdata[OUT_DATA_W-1:SLOT_W+DATA_W+3]));
			compare_field("last", DATA_W'(want.last), DATA_W'(m_tlast));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_slots();
			table_answers_q.delete();
		end else begin
			// an operation's results never leave at its own accept edge, so order here is free
			if (s_tvalid && s_tready)
				run_table_op(s_tuser, s_tdata[SLOT_W-1:0], s_tdata[SLOT_W +: DATA_W],
					s_tdata[SLOT_W+DATA_W +: DATA_W]);
			if (m_tvalid && m_tready)
				check_answer();
		end
		answers_waiting = table_answers_q.size();
	end

endmodule

### tb/sv/tb_time_triggered_task_scheduler_top.sv
// testbench top for the task scheduler: clock, reset, stimulus and verdict
module tb_time_triggered_task_scheduler_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tts_pkg::*;

	localparam int NUM_SLOTS    = 8;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	// op codes the block does not define
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]       s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	int          fail_cnt;
	int          answers_waiting;
	int          answers_seen;
	int          slot_answers;
	int          items_sent = 0;
	int unsigned cycle_cnt  = 0;
	bit          hold_req   = 1'b0;
	bit          steady     = 1'b0;

	time_triggered_task_scheduler_top #(.NUM_SLOTS(NUM_SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	tts_sched_checker #(.NUM_SLOTS(NUM_SLOTS)) sched_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.fail_cnt        (fail_cnt),
		.answers_waiting (answers_waiting),
		.answers_seen    (answers_seen),
		.slot_answers    (slot_answers)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// mostly no gap, some short ones, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ELAPSED_MAX;
			2, 3: return $urandom();
			default: return DATA_W'($urandom_range(0, 6));
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] rand_slot();
		return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
	endfunction

	function automatic logic [OP_W-1:0] rand_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18)
			return OP_TICK;
		if (r < 40)
			return OP_DISPATCH;
		if (r < 64)
			return OP_ADD;
		if (r < 76)
			return OP_DELETE;
		if (r < 89)
			return OP_MODIFY;
		if (r < 92)
			return OP_INIT;
		if (r < 96)
			return OP_SPARE_A;
		return OP_SPARE_B;
	endfunction

	// result side: random stalls, or one long hold-off when asked
	initial begin : result_sink
		int gap;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = steady ? 0 : idle_len();
				if (gap == 0) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// called at a rising edge; returns at the edge that accepts the transaction
	task automatic issue(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
			input logic [DATA_W-1:0] per, input logic [DATA_W-1:0] dly);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_DATA_W - SLOT_W - 2 * DATA_W){1'b0}}, dly, per, slot};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// mostly tick then dispatch, as a real timer would drive it, mixed with table edits
	task automatic run_random(input int n);
		int done;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 99) < 55) begin
				issue(OP_TICK, rand_slot(), rand_word(), rand_word());
				issue(OP_DISPATCH, rand_slot(), rand_word(), rand_word());
				done += 2;
			end else begin
				issue(rand_op(), rand_slot(), rand_word(), rand_word());
				done++;
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (answers_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, then overrun
		issue(OP_DISPATCH, rand_slot(), $urandom(), $urandom());
		issue(OP_TICK, rand_slot(), $urandom(), $urandom());
		issue(OP_TICK, rand_slot(), $urandom(), $urandom());
		issue(OP_DISPATCH, rand_slot(), $urandom(), $urandom());
		// fill every slot so that the second dispatch finds all of them due
		issue(OP_ADD, rand_slot(), 32'd0, 32'd0);
		issue(OP_ADD, rand_slot(), 32'd0, ELAPSED_MAX);
		issue(OP_ADD, rand_slot(), 32'd1, 32'd1);
		issue(OP_ADD, rand_slot(), 32'd0, 32'd7);
		issue(OP_ADD, rand_slot(), ELAPSED_MAX, ELAPSED_MAX - 1);
		issue(OP_ADD, rand_slot(), 32'd0, 32'hAAAA_AAAA);
		issue(OP_ADD, rand_slot(), 32'd1, ELAPSED_MAX);
		issue(OP_ADD, rand_slot(), 32'd0, 32'h5555_5555);
		issue(OP_ADD, rand_slot(), $urandom(), $urandom());
		issue(OP_TICK, rand_slot(), $urandom(), $urandom());
		issue(OP_DISPATCH, rand_slot(), $urandom(), $urandom());
		// no tick pending here
		issue(OP_DISPATCH, rand_slot(), $urandom(), $urandom());
		issue(OP_MODIFY, 3'd2, ELAPSED_MAX, $urandom());
		issue(OP_DELETE, 3'd3, $urandom(), $urandom());
		issue(OP_ADD, rand_slot(), 32'hA5A5_5A5A, 32'd0);
		issue(OP_DELETE, 3'd7, $urandom(), $urandom());
		issue(OP_MODIFY, 3'd7, 32'h5A5A_A5A5, $urandom());
		issue(OP_SPARE_A, rand_slot(), $urandom(), $urandom());
		issue(OP_SPARE_B, rand_slot(), $urandom(), $urandom());
		issue(OP_INIT, rand_slot(), $urandom(), $urandom());
		issue(OP_DISPATCH, rand_slot(), $urandom(), $urandom());
		drain();

		run_random(40);
		drain();

		// results held back while transactions keep coming, so the input stalls
		hold_req = 1'b1;
		steady   = 1'b1;
		run_random(16);
		steady   = 1'b0;
		drain();

		// a stretch with no idling on either side
		steady = 1'b1;
		run_random(24);
		steady = 1'b0;
		drain();

		run_random(16);
		drain();

		$display("%0d operations sent, %0d results checked, %0d of them naming a slot",
			items_sent, answers_seen, slot_answers);
		$display("covered overrun, full table, all slots due, stalls and a long result hold-off");
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/tts_pkg.sv
hw/rtl/tts_mem.sv
hw/rtl/tts_alu.sv
hw/rtl/time_triggered_task_scheduler_top.sv
tb/sv/tts_sched_checker.sv
tb/sv/tb_time_triggered_task_scheduler_top.sv
